// File: rtl/scd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stock commit package
// Shared constants, operation and status codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package scd_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int RING_DEPTH   = 8;

	localparam int MASK_W = 16;
	localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	localparam logic [1:0] FN_COMMIT = 2'd0;
	localparam logic [1:0] FN_LOAD   = 2'd1;
	localparam logic [1:0] FN_READ   = 2'd2;
	localparam logic [1:0] FN_QUERY  = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_CHANNEL = 3'd1;
	localparam logic [2:0] ST_ALREADY     = 3'd2;
	localparam logic [2:0] ST_NO_STOCK    = 3'd3;
	localparam logic [2:0] ST_SAVE_FAIL   = 3'd4;

	typedef struct packed {
		logic capture;
		logic scan_en;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/scd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stock commit channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface scd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [7:0]  channel;
	logic [63:0] txn_hash;
	logic [7:0]  load_value;
	logic        save_ok;

	modport source (output valid, func, channel, txn_hash, load_value, save_ok,
		input ready);
	modport sink (input valid, func, channel, txn_hash, load_value, save_ok,
		output ready);
endinterface

interface scd_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] stock_count;
	logic       found;

	modport source (output valid, status, stock_count, found, input ready);
	modport sink (input valid, status, stock_count, found, output ready);
endinterface
`default_nettype wire

// File: rtl/scd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stock commit controller
// Sequences capture, the ring scan and the final update of each request.
// ----------------------------------------------------------------------------
module scd_ctrl
	import scd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    req_valid,
	output logic         req_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		req_ready   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
				if (req_valid) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// File: rtl/scd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stock commit datapath
// Holds the stock counts, the transaction ring, the scan flags and the
// response register.
// ----------------------------------------------------------------------------
module scd_dp
	import scd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_sts_t          sts,
	input  wire logic [1:0]  in_func,
	input  wire logic [7:0]  in_channel,
	input  wire logic [63:0] in_txn_hash,
	input  wire logic [7:0]  in_load_value,
	input  wire logic        in_save_ok,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       out_status,
	output logic [7:0]       out_stock_count,
	output logic             out_found
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [1:0]  func_q;
	logic [7:0]  channel_q;
	logic [63:0] hash_q;
	logic [7:0]  load_q;
	logic        save_q;

	logic [IDX_W-1:0] scan_idx_q;
	logic             pair_hit_q;
	logic             any_hit_q;
	logic             slot_same_q;
	logic [MASK_W-1:0] slot_mask_q;

	logic [7:0]        stock_q [NUM_CHANNELS];
	logic [63:0]       rec_hash_q [RING_DEPTH];
	logic [MASK_W-1:0] rec_mask_q [RING_DEPTH];
	logic [IDX_W-1:0]  next_slot_q;

	logic              out_valid_q;
	logic [2:0]        status_q;
	logic [7:0]        stock_count_q;
	logic              found_q;

	logic              ch_valid;
	logic [CH_W-1:0]   ch_idx;
	logic [MASK_W-1:0] ch_bit;
	logic              hit;
	logic [MASK_W-1:0] mask_rd;
	logic [7:0]        stock_rd;
	logic              commit_ok;
	logic              load_ok;
	logic [2:0]        status_d;
	logic [7:0]        stock_new;

	assign ch_valid = channel_q < 8'(NUM_CHANNELS);
	assign ch_idx   = channel_q[CH_W-1:0];
	assign ch_bit   = MASK_W'(1) << ch_idx;
	assign hit      = rec_hash_q[scan_idx_q] == hash_q;
	assign mask_rd  = rec_mask_q[scan_idx_q];
	assign stock_rd = ch_valid ? stock_q[ch_idx] : 8'd0;

	assign sts.scan_last = scan_idx_q == LAST_IDX;
	assign sts.out_free  = !out_valid_q || out_ready;

	always_comb begin
		status_d  = ST_OK;
		stock_new = stock_rd;
		commit_ok = 1'b0;
		load_ok   = 1'b0;
		case (func_q)
			FN_COMMIT: begin
				if (!ch_valid) begin
					status_d = ST_BAD_CHANNEL;
				end else if (pair_hit_q) begin
					status_d = ST_ALREADY;
				end else if (stock_rd == 8'd0) begin
					status_d = ST_NO_STOCK;
				end else if (!save_q) begin
					status_d = ST_SAVE_FAIL;
				end else begin
					commit_ok = 1'b1;
					stock_new = stock_rd - 8'd1;
				end
			end
			FN_LOAD: begin
				if (!ch_valid) begin
					status_d = ST_BAD_CHANNEL;
				end else begin
					load_ok   = 1'b1;
					stock_new = load_q;
				end
			end
			FN_READ: begin
				if (!ch_valid) begin
					status_d = ST_BAD_CHANNEL;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q    <= in_func;
			channel_q <= in_channel;
			hash_q    <= (in_txn_hash == 64'd0) ? 64'd1 : in_txn_hash;
			load_q    <= in_load_value;
			save_q    <= in_save_ok;
		end
		if (cmd.scan_en && scan_idx_q == next_slot_q) begin
			slot_mask_q <= mask_rd;
		end
		if (cmd.finish) begin
			status_q      <= status_d;
			stock_count_q <= ch_valid ? stock_new : 8'd0;
			found_q       <= (func_q == FN_QUERY) && any_hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q  <= '0;
			pair_hit_q  <= 1'b0;
			any_hit_q   <= 1'b0;
			slot_same_q <= 1'b0;
		end else if (cmd.capture) begin
			scan_idx_q  <= '0;
			pair_hit_q  <= 1'b0;
			any_hit_q   <= 1'b0;
			slot_same_q <= 1'b0;
		end else if (cmd.scan_en) begin
			if (!sts.scan_last) begin
				scan_idx_q <= scan_idx_q + IDX_W'(1);
			end
			if (hit && (mask_rd & ch_bit) != '0) begin
				pair_hit_q <= 1'b1;
			end
			if (hit && mask_rd != '0) begin
				any_hit_q <= 1'b1;
			end
			if (scan_idx_q == next_slot_q) begin
				slot_same_q <= hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				stock_q[i] <= 8'd0;
			end
			for (int i = 0; i < RING_DEPTH; i++) begin
				rec_hash_q[i] <= 64'd0;
				rec_mask_q[i] <= '0;
			end
			next_slot_q <= '0;
		end else if (cmd.finish) begin
			if (commit_ok || load_ok) begin
				stock_q[ch_idx] <= stock_new;
			end
			if (commit_ok) begin
				rec_hash_q[next_slot_q] <= hash_q;
				rec_mask_q[next_slot_q] <= slot_same_q ? (slot_mask_q | ch_bit) : ch_bit;
				next_slot_q <= (next_slot_q == LAST_IDX) ? '0 : next_slot_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = status_q;
	assign out_stock_count = stock_count_q;
	assign out_found       = found_q;

endmodule
`default_nettype wire

// File: rtl/stock_commit_with_dedup_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stock commit with deduplication ring
// Per-channel stock counts with a ring of recent transaction records that
// rejects repeated commits of the same transaction on the same channel.
// ----------------------------------------------------------------------------
// Every request is captured, then scanned against the ring, which compares
// the transaction hash against each stored record in turn, and is finished
// by applying the update and loading the response register. The response
// register holds the result until it is taken, while the next request is
// already accepted; a request whose response register is still occupied
// waits in the final step. Results come out in request order, one per
// request.
module stock_commit_with_dedup_table
	import scd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	scd_req_if.sink   req,
	scd_rsp_if.source rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    req_ready;

	assign req.ready = req_ready;

	scd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	scd_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_func         (req.func),
		.in_channel      (req.channel),
		.in_txn_hash     (req.txn_hash),
		.in_load_value   (req.load_value),
		.in_save_ok      (req.save_ok),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_stock_count (rsp.stock_count),
		.out_found       (rsp.found)
	);

	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("A second request was accepted while one was in progress.");

	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_BAD_CHANNEL |-> rsp.stock_count == 8'd0)
		else $error("An invalid channel response carries a nonzero stock count.");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.found |-> rsp.status == ST_OK)
		else $error("A found flag was raised on a response that is not ok.");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("The response register was overwritten before its transfer.");

endmodule
`default_nettype wire
